/* rtl/u8dec_pkg.sv */
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and byte-range constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CNT_W  = 2;

    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hEF;
    localparam logic [UNIT_W-1:0] CONT_OFFSET = 16'h0080;
    localparam logic [UNIT_W-1:0] SUBST_CHAR  = 16'h002A;

    localparam logic [CNT_W-1:0] PEND_NONE = 2'd0;
    localparam logic [CNT_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [CNT_W-1:0] PEND_BAD  = 2'd3;

    // one decoded result word
    typedef struct packed {
        logic              substituted;
        logic              end_of_string;
        logic [UNIT_W-1:0] code_unit;
    } res_t;

endpackage

/* rtl/utf8_stream_decoder_core.sv */
// Output: a completed character's word is registered in the output or skid register.
// Throughput: one byte per cycle while s_tready is high; decoding is combinational.
// Input stalls only while both result registers are full: an output stall with a word
// arriving fills the second register, and s_tready stays low until the output moves.
// Reset: asynchronous, active low; clears the pending count, accumulator and result valids.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Decodes a UTF-8 byte stream into 16-bit code units with end and substitution flags.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic [1:0]  m_tuser    // [0] end_of_string, [1] substituted
);

    logic            fire;
    logic            res_valid;
    u8dec_pkg::res_t res;
    u8dec_pkg::res_t out_res;

    assign fire = s_tvalid && s_tready;

    u8dec_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    u8dec_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.code_unit;
    assign m_tuser = {out_res.substituted, out_res.end_of_string};

endmodule

/* rtl/u8dec_step.sv */
// ----------------------------------------------------------------------------
// u8dec_step
// Decode state (pending count, accumulator) and the per-byte decode logic.
// ----------------------------------------------------------------------------
module u8dec_step
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [u8dec_pkg::BYTE_W-1:0]  in_byte,
    output logic                          res_valid,
    output u8dec_pkg::res_t               res
);

    logic [u8dec_pkg::CNT_W-1:0]  pending_reg, pending_next;
    logic [u8dec_pkg::UNIT_W-1:0] acc_reg, acc_next;
    logic [u8dec_pkg::UNIT_W-1:0] acc_shift;

    assign acc_shift = {acc_reg[u8dec_pkg::UNIT_W-7:0], 6'b0}
                       + {8'b0, in_byte} - u8dec_pkg::CONT_OFFSET;

    always_comb
    begin
        pending_next          = pending_reg;
        acc_next              = acc_reg;
        res_valid             = 1'b0;
        res.code_unit         = acc_shift;
        res.end_of_string     = 1'b0;
        res.substituted       = 1'b0;
        if (pending_reg != u8dec_pkg::PEND_NONE)
        begin
            // continuation byte: taken unchecked
            acc_next     = acc_shift;
            pending_next = pending_reg - 2'd1;
            res_valid    = (pending_reg == u8dec_pkg::PEND_ONE);
        end
        else
        begin
            priority if (in_byte == 8'h00)
            begin
                res_valid         = 1'b1;
                res.code_unit     = '0;
                res.end_of_string = 1'b1;
            end
            else if (in_byte <= u8dec_pkg::ASCII_MAX)
            begin
                res_valid     = 1'b1;
                res.code_unit = {8'b0, in_byte};
            end
            else if (in_byte >= u8dec_pkg::LEAD2_MIN && in_byte <= u8dec_pkg::LEAD2_MAX)
            begin
                acc_next     = {11'b0, in_byte[4:0]};
                pending_next = u8dec_pkg::PEND_ONE;
            end
            else if (in_byte >= u8dec_pkg::LEAD3_MIN && in_byte <= u8dec_pkg::LEAD3_MAX)
            begin
                acc_next     = {12'b0, in_byte[3:0]};
                pending_next = u8dec_pkg::PEND_TWO;
            end
            else
            begin
                // stray continuation or four-plus byte lead
                res_valid       = 1'b1;
                res.code_unit   = u8dec_pkg::SUBST_CHAR;
                res.substituted = 1'b1;
            end
        end
        if (!in_fire)
        begin
            pending_next = pending_reg;
            acc_next     = acc_reg;
            res_valid    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= u8dec_pkg::PEND_NONE;
            acc_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

    a_pend_reach: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != u8dec_pkg::PEND_BAD)
        else $error("pending count reached three");

    a_mid_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pending_reg == u8dec_pkg::PEND_TWO) |-> !res_valid)
        else $error("result emitted mid sequence");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.substituted && res.end_of_string))
        else $error("substitution and end of string together");

endmodule

/* rtl/u8dec_skid.sv */
// ----------------------------------------------------------------------------
// u8dec_skid
// Two-entry result register with registered ready toward the decoder.
// ----------------------------------------------------------------------------
module u8dec_skid
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  u8dec_pkg::res_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output u8dec_pkg::res_t out_data
);

    logic            main_valid_reg, main_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    u8dec_pkg::res_t main_reg, main_next;
    u8dec_pkg::res_t skid_reg, skid_next;
    logic            pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            // advance the skid word, or the incoming word, into the output slot
            main_valid_next = skid_valid_reg || in_valid;
            main_next       = skid_valid_reg ? skid_reg : in_data;
            skid_valid_next = skid_valid_reg && in_valid;
            skid_next       = in_data;
        end
        else if (in_valid)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = in_data;
            end
            else
            begin
                // hold the word aside while the output stalls
                skid_valid_next = 1'b1;
                skid_next       = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ready))
        else $error("skid filled without a stall");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && skid_valid_reg) |-> 1'b0)
        else $error("word offered while full");

endmodule

/* verif/utf8_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_unit_checker
// Watches both stream channels of the UTF-8 decoder, decodes every accepted
// byte on its own and compares each accepted code unit word with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module utf8_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] code_unit
    input  logic [1:0]  m_tuser,   // [0] end_of_string, [1] substituted
    output int          fail_count,
    output int          units_due
);

    localparam logic [u8dec_pkg::BYTE_W-1:0] NUL_BYTE = 8'h00;

    logic [u8dec_pkg::CNT_W-1:0]  cont_left;
    logic [u8dec_pkg::UNIT_W-1:0] partial_unit;
    u8dec_pkg::res_t              units_expected [$];

    initial
    begin
        fail_count = 0;
        units_due  = 0;
    end

    task automatic report(input string what, input logic [u8dec_pkg::UNIT_W-1:0] got,
                          input logic [u8dec_pkg::UNIT_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // append one predicted word at the tail of the queue
    task automatic queue_unit(input u8dec_pkg::res_t unit);
        units_expected = {units_expected, unit};
    endtask

    // advance the decode state by one byte, queue a word when one completes
    task automatic decode_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
        u8dec_pkg::res_t unit;
        unit = '0;
        if (cont_left != u8dec_pkg::PEND_NONE)
        begin
            // continuation bytes go in unchecked, modulo 2^16
            partial_unit = (partial_unit << 6) + {8'h00, b} - u8dec_pkg::CONT_OFFSET;
            cont_left    = cont_left - 1'b1;
            if (cont_left == u8dec_pkg::PEND_NONE)
            begin
                unit.code_unit = partial_unit;
                queue_unit(unit);
            end
        end
        else if (b == NUL_BYTE)
        begin
            unit.end_of_string = 1'b1;
            queue_unit(unit);
        end
        else if (b <= u8dec_pkg::ASCII_MAX)
        begin
            unit.code_unit = {8'h00, b};
            queue_unit(unit);
        end
        else if (b >= u8dec_pkg::LEAD2_MIN && b <= u8dec_pkg::LEAD2_MAX)
        begin
            partial_unit = {8'h00, b - u8dec_pkg::LEAD2_MIN};
            cont_left    = u8dec_pkg::PEND_ONE;
        end
        else if (b >= u8dec_pkg::LEAD3_MIN && b <= u8dec_pkg::LEAD3_MAX)
        begin
            partial_unit = {8'h00, b - u8dec_pkg::LEAD3_MIN};
            cont_left    = u8dec_pkg::PEND_TWO;
        end
        else
        begin
            // stray continuation or four-plus byte lead
            unit.code_unit   = u8dec_pkg::SUBST_CHAR;
            unit.substituted = 1'b1;
            queue_unit(unit);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        u8dec_pkg::res_t got_unit;
        u8dec_pkg::res_t want_unit;
        if (!rst_n)
        begin
            cont_left    = u8dec_pkg::PEND_NONE;
            partial_unit = '0;
            units_expected.delete();
            units_due   <= 0;
        end
        else
        begin
            // output word first: it can only stem from an earlier byte
            if (m_tvalid && m_tready)
            begin
                got_unit = {m_tuser, m_tdata};
                if (units_expected.size() == 0)
                    report("word with none due", got_unit.code_unit, '0);
                else
                begin
                    want_unit = units_expected.pop_front();
                    if (got_unit.code_unit !== want_unit.code_unit)
                        report("code_unit", got_unit.code_unit, want_unit.code_unit);
                    if (got_unit.end_of_string !== want_unit.end_of_string)
                        report("end_of_string", {15'd0, got_unit.end_of_string},
                               {15'd0, want_unit.end_of_string});
                    if (got_unit.substituted !== want_unit.substituted)
                        report("substituted", {15'd0, got_unit.substituted},
                               {15'd0, want_unit.substituted});
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            units_due <= units_expected.size();
        end
    end

endmodule

/* verif/tb_utf8_stream_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core
// Drives the UTF-8 decoder with directed edge bytes and then mostly
// well-formed random sequences mixed with broken ones, under random idling on
// both sides, and gives the verdict from the checker's failure and due counts.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_core;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

    localparam int BYTE_TARGET   = 1600;
    localparam int HOLD_AT       = 600;
    localparam int DRAIN_AT      = 1100;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_IDLE      = 14;
    localparam int TAIL_CYCLES   = 8;
    localparam int MODE_SPAN     = 100;
    localparam int RUN_LIMIT_NS  = 1000000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    int          fail_count;
    int          units_due;
    int          bytes_sent   = 0;
    int          words_taken  = 0;
    bit          long_hold_req = 1'b0;
    idle_mode_t  src_mode     = IDLE_NONE;
    idle_mode_t  snk_mode     = IDLE_FULL;

    utf8_stream_decoder_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    utf8_unit_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .units_due  (units_due)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int draw_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(MAX_IDLE, 0);
            default:   return ($urandom_range(3, 0) == 0) ? $urandom_range(MAX_IDLE, 0) : 0;
        endcase
    endfunction

    // offer one byte; valid stays high across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int idle;
        if (bytes_sent % MODE_SPAN == 0)
            src_mode = idle_mode_t'($urandom_range(2, 0));
        idle = draw_idle(src_mode);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    task automatic send_sequence();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 25)
            send_byte(8'($urandom_range(u8dec_pkg::ASCII_MAX, 1)));
        else if (pick < 45)
        begin
            send_byte(8'($urandom_range(u8dec_pkg::LEAD2_MAX, u8dec_pkg::LEAD2_MIN)));
            send_byte(cont_byte());
        end
        else if (pick < 65)
        begin
            send_byte(8'($urandom_range(u8dec_pkg::LEAD3_MAX, u8dec_pkg::LEAD3_MIN)));
            send_byte(cont_byte());
            send_byte(cont_byte());
        end
        else if (pick < 70)
            send_byte(8'h00);
        else if (pick < 76)
            send_byte(cont_byte());
        else if (pick < 82)
            send_byte(8'($urandom_range(8'hFF, 8'hF0)));
        else if (pick < 92)
        begin
            // lead followed by an arbitrary byte in continuation position
            send_byte(8'($urandom_range(u8dec_pkg::LEAD3_MAX, u8dec_pkg::LEAD2_MIN)));
            send_byte(8'($urandom_range(8'hFF, 8'h00)));
        end
        else
            send_byte(8'($urandom_range(8'hFF, 8'h00)));
    endtask

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int idle;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (words_taken % MODE_SPAN == 0)
                snk_mode = idle_mode_t'($urandom_range(2, 0));
            idle = draw_idle(snk_mode);
            if (idle > 0)
            begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            words_taken++;
        end
    end

    initial
    begin : stimulus
        logic [7:0] directed [$];
        bit         hold_done;
        bit         drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        // edges of each byte class, then well-formed and broken multi-byte forms
        directed = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hF0, 8'hFD, 8'hFF,
                     8'hC0, 8'h80, 8'hDF, 8'hBF,
                     8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hC3, 8'h00,
                     8'hE2, 8'hFF, 8'h41};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        while (bytes_sent < BYTE_TARGET)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!drain_done && bytes_sent >= DRAIN_AT)
            begin
                // pause until every due word is out
                drain_done = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge clk); while (units_due != 0);
            end
            send_sequence();
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (units_due != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && units_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
